@@ rtl/pcug_pkg.sv @@
// ----------------------------------------------------------------------------
// pcug_pkg
// Types, constants and helpers for the Philox-4x32 counter-based generator.
// ----------------------------------------------------------------------------
package pcug_pkg;

	localparam int PCUG_ROUNDS = 10;

	localparam int WORD_W = 32;
	localparam int SEED_W = 64;
	localparam int SCEN_W = 40;
	localparam int TS_W   = 24;
	localparam int DIM_W  = 8;
	localparam int DRAW_W = 24;
	localparam int FRAC_W = 54;
	localparam int FRAC_DROP = 11;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SEED_W-1:0] seed_t;
	typedef logic [SCEN_W-1:0] scen_t;
	typedef logic [TS_W-1:0]   ts_t;
	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [DRAW_W-1:0] draw_t;
	typedef logic [FRAC_W-1:0] frac_t;

	localparam word_t MUL0  = 32'hD251_1F53;
	localparam word_t MUL1  = 32'hCD9E_8D57;
	localparam word_t WEYL0 = 32'h9E37_79B9;
	localparam word_t WEYL1 = 32'hBB67_AE85;

	typedef struct packed {
		word_t c3;
		word_t c2;
		word_t c1;
		word_t c0;
	} ctr_t;

	// (w0:w1) >> 11, doubled, or 1 when the kept part is zero
	function automatic frac_t frac_of(word_t w0, word_t w1);
		logic [2*WORD_W-1:0]          raw;
		logic [2*WORD_W-FRAC_DROP-1:0] kept;
		raw  = {w0, w1};
		kept = raw[2*WORD_W-1:FRAC_DROP];
		if (kept == '0) begin
			frac_of = frac_t'(1);
		end else begin
			frac_of = {kept, 1'b0};
		end
	endfunction

endpackage

@@ rtl/pcug_draw_if.sv @@
// ----------------------------------------------------------------------------
// pcug_draw_if
// Request channel: one item names one draw.
// ----------------------------------------------------------------------------
interface pcug_draw_if;
	import pcug_pkg::*;

	logic  valid;
	logic  ready;
	scen_t scen_num;
	ts_t   step_num;
	dim_t  dimension;
	draw_t draw_num;

	modport source(output valid, scen_num, step_num, dimension, draw_num,
		input ready);
	modport sink(input valid, scen_num, step_num, dimension, draw_num,
		output ready);
endinterface

@@ rtl/pcug_result_if.sv @@
// ----------------------------------------------------------------------------
// pcug_result_if
// Result channel: four Philox words and the uniform fraction.
// ----------------------------------------------------------------------------
interface pcug_result_if;
	import pcug_pkg::*;

	logic  valid;
	logic  ready;
	word_t word_zero;
	word_t word_one;
	word_t word_two;
	word_t word_three;
	frac_t uniform_fraction;

	modport source(output valid, word_zero, word_one, word_two, word_three,
		uniform_fraction, input ready);
	modport sink(input valid, word_zero, word_one, word_two, word_three,
		uniform_fraction, output ready);
endinterface

@@ rtl/pcug_round.sv @@
// ----------------------------------------------------------------------------
// pcug_round
// One registered Philox-4x32 round with its bumped key.
// ----------------------------------------------------------------------------
module pcug_round #(
	parameter int RND = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            valid_in,
	input  pcug_pkg::ctr_t  ctr_in,
	input  pcug_pkg::seed_t seed,
	output logic            valid_out,
	output pcug_pkg::ctr_t  ctr_out
);
	import pcug_pkg::*;

	localparam logic [63:0] OFF0_WIDE = 64'(RND) * {32'd0, WEYL0};
	localparam logic [63:0] OFF1_WIDE = 64'(RND) * {32'd0, WEYL1};
	localparam word_t OFF0 = OFF0_WIDE[31:0];
	localparam word_t OFF1 = OFF1_WIDE[31:0];

	word_t       k0;
	word_t       k1;
	logic [63:0] p0;
	logic [63:0] p1;
	ctr_t        nxt;
	ctr_t        ctr_s1;
	logic        valid_s1;

	assign k0 = seed[31:0] + OFF0;
	assign k1 = seed[63:32] + OFF1;
	assign p0 = {32'd0, MUL0} * {32'd0, ctr_in.c0};
	assign p1 = {32'd0, MUL1} * {32'd0, ctr_in.c2};

	always_comb begin
		nxt.c0 = p1[63:32] ^ ctr_in.c1 ^ k0;
		nxt.c1 = p1[31:0];
		nxt.c2 = p0[63:32] ^ ctr_in.c3 ^ k1;
		nxt.c3 = p0[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctr_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign ctr_out   = ctr_s1;
endmodule

@@ rtl/philox_counter_uniform_generator_top.sv @@
// ----------------------------------------------------------------------------
// philox_counter_uniform_generator_top
// Philox-4x32 counter-based generator with a 54-bit uniform fraction.
//
//  port     | dir  | carries
//  ---------+------+------------------------------------------------
//  draw     | sink | scen_num, step_num, dimension, draw_num
//  result   | src  | word_zero..word_three, uniform_fraction
//  seed_*   | in   | seed write enable and 64-bit key
//
// One item per cycle while the result side does not stall. Stages: a counter
// register, one stage per round (two 32x32 multiplies each), an output register.
// Reset clears valid bits and sets the seed to zero.
// Each stage holds its item only while the next one is full and stalled, so
// bubbles close up and draw.ready stays high while the result register is empty.
// ----------------------------------------------------------------------------
module philox_counter_uniform_generator_top #(
	parameter int ROUNDS = pcug_pkg::PCUG_ROUNDS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            seed_we,
	input  pcug_pkg::seed_t seed_wdata,
	pcug_draw_if.sink       draw,
	pcug_result_if.source   result
);
	import pcug_pkg::*;

	localparam int LAST = ROUNDS + 1;

	seed_t       seed_q;
	ctr_t        ctr_st [ROUNDS+1];
	logic [LAST:0] vld;
	logic [LAST:0] rdy;
	ctr_t        ctr_s0;
	logic        valid_s0;
	ctr_t        ctr_sout;
	frac_t       frac_sout;
	logic        valid_sout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	always_comb begin
		rdy[LAST] = !vld[LAST] || result.ready;
		for (int i = LAST - 1; i >= 0; i--) begin
			rdy[i] = !vld[i] || rdy[i+1];
		end
	end

	assign draw.ready = rdy[0];

	// counter stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (rdy[0]) begin
			valid_s0 <= draw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			ctr_s0.c0 <= draw.scen_num[31:0];
			ctr_s0.c1 <= {draw.step_num, draw.scen_num[39:32]};
			ctr_s0.c2 <= {draw.draw_num, draw.dimension};
			ctr_s0.c3 <= '0;
		end
	end

	assign ctr_st[0] = ctr_s0;
	assign vld[0]    = valid_s0;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		pcug_round #(.RND(r)) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (rdy[r+1]),
			.valid_in  (vld[r]),
			.ctr_in    (ctr_st[r]),
			.seed      (seed_q),
			.valid_out (vld[r+1]),
			.ctr_out   (ctr_st[r+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sout <= 1'b0;
		end else if (rdy[LAST]) begin
			valid_sout <= vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[LAST]) begin
			ctr_sout  <= ctr_st[ROUNDS];
			frac_sout <= frac_of(ctr_st[ROUNDS].c0, ctr_st[ROUNDS].c1);
		end
	end

	assign vld[LAST] = valid_sout;

	assign result.valid            = valid_sout;
	assign result.word_zero        = ctr_sout.c0;
	assign result.word_one         = ctr_sout.c1;
	assign result.word_two         = ctr_sout.c2;
	assign result.word_three       = ctr_sout.c3;
	assign result.uniform_fraction = frac_sout;
endmodule

@@ rtl/pcug_checker.sv @@
// ----------------------------------------------------------------------------
// pcug_checker
// Port-level checks on the generator, bound to the top level.
// ----------------------------------------------------------------------------
module pcug_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            draw_ready,
	input logic            res_valid,
	input logic            res_ready,
	input pcug_pkg::word_t res_w0,
	input pcug_pkg::word_t res_w1,
	input pcug_pkg::frac_t res_frac
);
	import pcug_pkg::*;

	a_frac_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_frac == frac_of(res_w0, res_w1))
		else $error("fraction does not follow words zero and one");

	a_frac_open: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_frac != '0 && (!res_frac[0] || res_frac == frac_t'(1)))
		else $error("fraction outside the open interval");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> draw_ready)
		else $error("draw not ready while result register empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_w0) && $stable(res_frac))
		else $error("stalled result item changed");
endmodule

bind philox_counter_uniform_generator_top pcug_checker u_pcug_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.draw_ready (draw.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_w0     (result.word_zero),
	.res_w1     (result.word_one),
	.res_frac   (result.uniform_fraction)
);
